[rtl/core/bfcr_pkg.sv]
`default_nettype none

package bfcr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int COORD_W     = 16;
    localparam int SCALE_W     = 5;
    localparam int CODE_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;

    // command kinds handed from front to back
    localparam logic [1:0] K_SET  = 2'd0;  // load cursor and line top
    localparam logic [1:0] K_ADV4 = 2'd1;  // space
    localparam logic [1:0] K_ADV6 = 2'd2;  // blank glyph
    localparam logic [1:0] K_DRAW = 2'd3;

    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CODE_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CODE_W-1:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [GLYPH_BITS-1:0] glyph;
    } t_cmd;

    // rows top first, within a row the MSB is the left column
    function automatic logic [GLYPH_BITS-1:0] glyph_rom(input logic [CODE_W-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43: g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47: g = {5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F};
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            8'h4A: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
            8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            8'h2F: g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfcr_front.sv]
`default_nettype none

module bfcr_front (
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_mode,
    input  wire logic [bfcr_pkg::COORD_W-1:0]    i_origin_x,
    input  wire logic [bfcr_pkg::COORD_W-1:0]    i_origin_y,
    input  wire logic [bfcr_pkg::CODE_W-1:0]     i_char_code,
    input  wire logic                            i_q_full,
    output logic                                 o_push,
    output bfcr_pkg::t_cmd                       o_cmd
);

    logic [bfcr_pkg::CODE_W-1:0]     w_code;
    logic [bfcr_pkg::GLYPH_BITS-1:0] w_glyph;

    // fold a-z onto A-Z
    assign w_code = (i_char_code >= bfcr_pkg::CH_LOW_A && i_char_code <= bfcr_pkg::CH_LOW_Z)
                    ? i_char_code - bfcr_pkg::CASE_OFS : i_char_code;
    assign w_glyph = bfcr_pkg::glyph_rom(w_code);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.x     = i_origin_x;
        o_cmd.y     = i_origin_y;
        o_cmd.glyph = w_glyph;
        if (!i_mode) begin
            o_cmd.kind = bfcr_pkg::K_SET;
        end else if (w_code == bfcr_pkg::CH_SPACE) begin
            o_cmd.kind = bfcr_pkg::K_ADV4;
        end else if (w_glyph == '0) begin
            o_cmd.kind = bfcr_pkg::K_ADV6;
        end else begin
            o_cmd.kind = bfcr_pkg::K_DRAW;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bfcr_fifo.sv]
`default_nettype none

module bfcr_fifo #(
    parameter int DEPTH = bfcr_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bfcr_pkg::t_cmd i_data,
    input  wire logic           i_pop,
    output bfcr_pkg::t_cmd      o_data,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bfcr_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

[rtl/core/bfcr_back.sv]
`default_nettype none

module bfcr_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bfcr_pkg::SCALE_W-1:0]    i_scale,
    input  wire bfcr_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_q_empty,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bfcr_pkg::COORD_W-1:0]         o_pixel_x,
    output logic [bfcr_pkg::COORD_W-1:0]         o_pixel_y,
    output logic                                 o_last_pixel
);

    localparam int CW = bfcr_pkg::COORD_W;
    localparam int GB = bfcr_pkg::GLYPH_BITS;
    localparam logic [2:0] LAST_COL = 3'(bfcr_pkg::GLYPH_COLS - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_cursor_x, n_cursor_x;
    logic [CW-1:0] r_line_y, n_line_y;
    logic [GB-1:0] r_sr, n_sr;
    logic [2:0]    r_col, n_col;
    logic [CW-1:0] r_x_acc, n_x_acc;
    logic [CW-1:0] r_y_acc, n_y_acc;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_x, n_out_x;
    logic [CW-1:0] r_out_y, n_out_y;
    logic          r_out_last, n_out_last;

    logic [CW-1:0] w_scale, w_adv4, w_adv6;
    logic          w_out_free, w_lit, w_tail_zero, w_step;

    assign w_scale = {{(CW - bfcr_pkg::SCALE_W){1'b0}}, i_scale};
    assign w_adv4  = {w_scale[CW-3:0], 2'b00};
    assign w_adv6  = w_adv4 + {w_scale[CW-2:0], 1'b0};

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_lit       = r_sr[GB-1];
    assign w_tail_zero = (r_sr[GB-2:0] == '0);
    assign w_step      = (r_state == S_SCAN) && (!w_lit || w_out_free);

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        n_state     = r_state;
        n_cursor_x  = r_cursor_x;
        n_line_y    = r_line_y;
        n_sr        = r_sr;
        n_col       = r_col;
        n_x_acc     = r_x_acc;
        n_y_acc     = r_y_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;

        if (o_pop) begin
            case (i_cmd.kind)
                bfcr_pkg::K_SET: begin
                    n_cursor_x = i_cmd.x;
                    n_line_y   = i_cmd.y;
                end
                bfcr_pkg::K_ADV4: n_cursor_x = r_cursor_x + w_adv4;
                bfcr_pkg::K_ADV6: n_cursor_x = r_cursor_x + w_adv6;
                bfcr_pkg::K_DRAW: begin
                    n_state = S_SCAN;
                    n_sr    = i_cmd.glyph;
                    n_col   = '0;
                    n_x_acc = r_cursor_x;
                    n_y_acc = r_line_y;
                end
                default: n_state = S_IDLE;
            endcase
        end

        // one dot position per cycle; waits only on a lit dot with the output busy
        if (w_step) begin
            if (w_lit) begin
                n_out_valid = 1'b1;
                n_out_x     = r_x_acc;
                n_out_y     = r_y_acc;
                n_out_last  = w_tail_zero;
            end
            n_sr = {r_sr[GB-2:0], 1'b0};
            if (r_col == LAST_COL) begin
                n_col   = '0;
                n_x_acc = r_cursor_x;
                n_y_acc = r_y_acc + w_scale;
            end else begin
                n_col   = r_col + 1'b1;
                n_x_acc = r_x_acc + w_scale;
            end
            if (w_tail_zero) begin
                n_state    = S_IDLE;
                n_cursor_x = r_cursor_x + w_adv6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor_x  <= '0;
            r_line_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor_x  <= n_cursor_x;
            r_line_y    <= n_line_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr       <= n_sr;
        r_col      <= n_col;
        r_x_acc    <= n_x_acc;
        r_y_acc    <= n_y_acc;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_last_pixel = r_out_last;

    a_scan_has_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_sr != '0))
        else $error("scan running with no dots left");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_col <= LAST_COL))
        else $error("column counter out of range");
    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_IDLE) |=> (r_out_valid && r_out_last))
        else $error("scan ended without a last beat");

endmodule

`default_nettype wire

[rtl/core/bitmap_font_char_rasterizer_top.sv]
// Flow: an input beat is written into the command queue and popped from it once the back end
// is idle; cursor, space and blank items update the cursor at that pop. A character then scans
// its 35 dot positions one per cycle up to its last lit dot, waiting on a lit dot while the
// output is stalled, and each beat is offered the cycle after its dot. The queue takes new
// input beats while a character scans; the next item is popped only after the scan ends.
// Reset (synchronous, active low): cursor and line top to 0, pixel scale to 1, queue empty.
`default_nettype none

module bitmap_font_char_rasterizer_top #(
    parameter int QUEUE_DEPTH = bfcr_pkg::QUEUE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [bfcr_pkg::SCALE_W-1:0]    i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_mode,
    input  wire logic [bfcr_pkg::COORD_W-1:0]    i_origin_x,
    input  wire logic [bfcr_pkg::COORD_W-1:0]    i_origin_y,
    input  wire logic [bfcr_pkg::CODE_W-1:0]     i_char_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bfcr_pkg::COORD_W-1:0]         o_pixel_x,
    output logic [bfcr_pkg::COORD_W-1:0]         o_pixel_y,
    output logic                                 o_last_pixel
);

    logic [bfcr_pkg::SCALE_W-1:0] r_pixel_scale;
    bfcr_pkg::t_cmd               w_push_cmd, w_pop_cmd;
    logic                         w_push, w_pop, w_full, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_scale <= bfcr_pkg::SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_pixel_scale <= i_cfg_wr_data;
        end
    end

    bfcr_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_char_code (i_char_code),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    bfcr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bfcr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale      (r_pixel_scale),
        .i_cmd        (w_pop_cmd),
        .i_q_empty    (w_empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule

`default_nettype wire

[tb/bitmap_font_char_rasterizer_top_tb.sv]
`default_nettype none

module bitmap_font_char_rasterizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = bfcr_pkg::COORD_W;
    localparam int CODE_W     = bfcr_pkg::CODE_W;
    localparam int SCALE_W    = bfcr_pkg::SCALE_W;
    localparam int GLYPH_ROWS = bfcr_pkg::GLYPH_ROWS;
    localparam int GLYPH_COLS = bfcr_pkg::GLYPH_COLS;

    localparam logic MODE_CURSOR = 1'b0;
    localparam logic MODE_CHAR   = 1'b1;

    localparam logic [CODE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CODE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CODE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CODE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CODE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CODE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CODE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CODE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CODE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CH_ALL1  = 8'hFF;

    localparam int SLOT_DIGIT = 26;
    localparam int SLOT_SLASH = 36;
    localparam int SLOT_DASH  = 37;
    localparam int SLOT_DOT   = 38;
    localparam int NUM_SLOTS  = 39;

    localparam int QUIET_CYCLES   = 100;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 40;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_dot;

    class raster_scoreboard;
        t_dot               pending_dots[$];
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] top_y;
        logic [SCALE_W-1:0] scale;
        int                 errors;
        bit [4:0]           font_rows [NUM_SLOTS][GLYPH_ROWS];

        function new();
            cur_x  = '0;
            top_y  = '0;
            scale  = bfcr_pkg::SCALE_RESET;
            errors = 0;
            // bit 4 is the leftmost column
            font_rows = '{
                '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
                '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
                '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
                '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
                '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
                '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
                '{5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F},
                '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
                '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
                '{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E},
                '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
                '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
                '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
                '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
                '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
                '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
                '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
                '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
                '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
                '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
                '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
                '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
                '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
                '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
                '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
                '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
                '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
                '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
                '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
                '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
                '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
                '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
                '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
                '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
                '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
                '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
                '{5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10},
                '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
                '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}
            };
        endfunction

        function int glyph_slot(logic [CODE_W-1:0] c);
            if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A);
            if (c >= CH_ZERO && c <= CH_NINE) return SLOT_DIGIT + int'(c - CH_ZERO);
            if (c == CH_SLASH) return SLOT_SLASH;
            if (c == CH_DASH) return SLOT_DASH;
            if (c == CH_DOT) return SLOT_DOT;
            return -1;
        endfunction

        // expected dots of one accepted input beat, and the cursor update
        function void note_beat(logic mode, logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                                logic [CODE_W-1:0] code);
            logic [CODE_W-1:0] c;
            int                slot;
            int                total;
            int                k;
            t_dot              d;
            if (mode == MODE_CURSOR) begin
                cur_x = ox;
                top_y = oy;
                return;
            end
            c = code;
            if (c >= bfcr_pkg::CH_LOW_A && c <= bfcr_pkg::CH_LOW_Z) c = c - bfcr_pkg::CASE_OFS;
            if (c == bfcr_pkg::CH_SPACE) begin
                cur_x = cur_x + COORD_W'(scale) * 16'd4;
                return;
            end
            slot = glyph_slot(c);
            if (slot >= 0) begin
                total = 0;
                for (int r = 0; r < GLYPH_ROWS; r++) total += $countones(font_rows[slot][r]);
                k = 0;
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    for (int col = 0; col < GLYPH_COLS; col++) begin
                        if (font_rows[slot][r][4-col]) begin
                            k++;
                            d.x    = cur_x + COORD_W'(col) * COORD_W'(scale);
                            d.y    = top_y + COORD_W'(r) * COORD_W'(scale);
                            d.last = (k == total);
                            pending_dots.push_back(d);
                        end
                    end
                end
            end
            cur_x = cur_x + COORD_W'(scale) * 16'd6;
        endfunction

        function void check_dot(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
            t_dot e;
            if (pending_dots.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat x=%h y=%h last=%b", $time, x, y, last);
                return;
            end
            e = pending_dots.pop_front();
            if (x !== e.x) begin
                errors++;
                $display("%0t: pixel_x expected %h actual %h", $time, e.x, x);
            end
            if (y !== e.y) begin
                errors++;
                $display("%0t: pixel_y expected %h actual %h", $time, e.y, y);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: last_pixel expected %b actual %b", $time, e.last, last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [SCALE_W-1:0] i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_mode;
    logic [COORD_W-1:0] i_origin_x;
    logic [COORD_W-1:0] i_origin_y;
    logic [CODE_W-1:0]  i_char_code;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [COORD_W-1:0] o_pixel_x;
    logic [COORD_W-1:0] o_pixel_y;
    logic               o_last_pixel;

    raster_scoreboard sb = new();
    bit tx_calm;
    bit rx_calm;

    bitmap_font_char_rasterizer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_last_pixel  (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall before each beat
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = rx_calm ? 0 : $urandom_range(0, 15);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_dot(o_pixel_x, o_pixel_y, o_last_pixel);
    end

    task automatic send_beat(input logic mode, input logic [COORD_W-1:0] ox,
                             input logic [COORD_W-1:0] oy, input logic [CODE_W-1:0] code);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_mode      = mode;
        i_origin_x  = ox;
        i_origin_y  = oy;
        i_char_code = code;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(mode, ox, oy, code);
    endtask

    task automatic send_char(input logic [CODE_W-1:0] code);
        send_beat(MODE_CHAR, COORD_W'($urandom), COORD_W'($urandom), code);
    endtask

    task automatic send_cursor(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        send_beat(MODE_CURSOR, x, y, CODE_W'($urandom));
    endtask

    // stop sending, let every expected dot arrive, then give blanks time to retire
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_dots.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.scale = v;
    endtask

    task automatic send_random_item();
        int                 r;
        int                 k;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            // bias some origins toward the wrap points
            x = (r < 4) ? 16'h8000 - COORD_W'($urandom_range(0, 200)) : COORD_W'($urandom);
            y = (r < 7) ? COORD_W'(-$urandom_range(0, 100)) : COORD_W'($urandom);
            send_cursor(x, y);
        end else if (r < 20) begin
            send_char(CODE_W'($urandom));
        end else if (r < 30) begin
            send_char(bfcr_pkg::CH_SPACE);
        end else begin
            k = $urandom_range(0, NUM_SLOTS - 1);
            if (k < SLOT_DIGIT)
                send_char(($urandom_range(0, 1) ? bfcr_pkg::CH_LOW_A : CH_UP_A) + CODE_W'(k));
            else if (k < SLOT_SLASH)
                send_char(CH_ZERO + CODE_W'(k - SLOT_DIGIT));
            else if (k == SLOT_SLASH)
                send_char(CH_SLASH);
            else if (k == SLOT_DASH)
                send_char(CH_DASH);
            else
                send_char(CH_DOT);
        end
    endtask

    initial begin
        logic [SCALE_W-1:0] sc;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_CURSOR;
        i_origin_x    = '0;
        i_origin_y    = '0;
        i_char_code   = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: glyph classes, case folding, blanks, wrap, scale extremes
        write_scale(5'd1);
        send_beat(MODE_CURSOR, 16'h0000, 16'h0000, CH_ALL1);
        send_char(CH_UP_A);
        send_char(bfcr_pkg::CH_LOW_A + 8'd1);
        send_char(bfcr_pkg::CH_SPACE);
        send_char(CH_NUL);
        send_char(CH_ALL1);
        send_char(CH_BANG);
        send_char(CH_SLASH);
        send_char(CH_DASH);
        send_char(CH_DOT);
        send_char(CH_ZERO);
        send_char(CH_NINE);
        send_char(bfcr_pkg::CH_LOW_Z);
        send_beat(MODE_CHAR, 16'hFFFF, 16'hFFFF, CH_UP_A + 8'd12);
        send_cursor(16'h7FFF, 16'h8000);
        send_char(CH_UP_A + 8'd12);
        write_scale(5'd31);
        send_cursor(16'hFFF0, 16'h7FF0);
        send_char(CH_UP_A + 8'd22);
        send_char(bfcr_pkg::CH_SPACE);
        send_char(CH_ZERO + 8'd8);
        write_scale(5'd0);
        send_char(CH_UP_A + 8'd1);
        send_char(bfcr_pkg::CH_SPACE);
        send_char(bfcr_pkg::CH_LOW_A + 8'd16);
        write_scale(5'd16);
        send_cursor(16'h8000, 16'hFFFF);
        send_char(CH_UP_A + 8'd16);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: sc = 5'd16;
                1: sc = 5'd1;
                2: sc = 5'd0;
                3: sc = 5'd31;
                4: sc = 5'd2;
                default: sc = SCALE_W'($urandom_range(1, 16));
            endcase
            write_scale(sc);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
        if (sb.errors == 0 && sb.pending_dots.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
